>>> rtl/core/thp_pkg.sv
// Shared types, constants and helpers of the sensor compensation pipeline.
package thp_pkg;

  localparam int CfgDataBits  = 48;
  localparam int CfgIndexBits = 3;

  localparam logic [CfgIndexBits-1:0] RegTempCalib   = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegPressCalibA = 3'd1;
  localparam logic [CfgIndexBits-1:0] RegPressCalibB = 3'd2;
  localparam logic [CfgIndexBits-1:0] RegPressCalibC = 3'd3;
  localparam logic [CfgIndexBits-1:0] RegHumCalibA   = 3'd4;
  localparam logic [CfgIndexBits-1:0] RegHumCalibB   = 3'd5;

  localparam int DivBits     = 64;
  localparam int DvsBits     = 31;
  localparam int DivStages   = DivBits;
  localparam int FrontStages = 12;
  localparam int BackStages  = 5;
  localparam int Latency     = FrontStages + 1 + DivStages + BackStages;

  localparam logic [31:0] HumTfOffset = 32'd76800;
  localparam logic [31:0] HumRound    = 32'd16384;
  localparam logic [31:0] HumCOffset  = 32'd32768;
  localparam logic [31:0] HumDOffset  = 32'd2097152;
  localparam logic [31:0] HumERound   = 32'd8192;
  localparam logic [31:0] HumMax      = 32'd419430400;
  localparam logic [16:0] HumQ10Max   = 17'd102400;

  localparam logic signed [32:0] PressTfOffset = 33'sd128000;
  localparam logic [63:0]        PressBias     = 64'h0000_8000_0000_0000;
  localparam logic [63:0]        PressAdcFull  = 64'd1048576;
  localparam logic [11:0]        PressNumScale = 12'd3125;

  typedef struct packed {
    logic [19:0] adc_temperature;
    logic [19:0] adc_pressure;
    logic [15:0] adc_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q8;
    logic [16:0]        humidity_q10;
  } out_item_t;

  typedef struct packed {
    logic [31:0] tf;
    logic [31:0] tc;
    logic [16:0] hum;
  } side_t;

  typedef struct packed {
    logic [DivBits-1:0] dividend;
    logic [DvsBits-1:0] divisor;
    logic               neg;
    logic               zero;
    side_t              side;
  } div_req_t;

  typedef struct packed {
    logic [DivBits-1:0] quo;
    logic               neg;
    logic               zero;
    side_t              side;
  } div_resp_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
    asr32 = $unsigned($signed(x) >>> sh);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned sh);
    asr64 = $unsigned($signed(x) >>> sh);
  endfunction

endpackage

>>> rtl/core/thp_hum.sv
// Nine-stage humidity compensation datapath with 32-bit wrapping arithmetic.
module thp_hum import thp_pkg::*; (
  input  logic        clk,
  input  logic [31:0] tf,
  input  logic [15:0] adc_humidity,
  input  logic [31:0] hum_calib_a,
  input  logic [39:0] hum_calib_b,
  output logic [16:0] humidity
);

  logic [7:0]         h1;
  logic signed [15:0] h2;
  logic [7:0]         h3;
  logic signed [15:0] h4;
  logic signed [15:0] h5;
  logic signed [7:0]  h6;

  assign h1 = hum_calib_a[7:0];
  assign h2 = hum_calib_a[23:8];
  assign h3 = hum_calib_a[31:24];
  assign h4 = hum_calib_b[15:0];
  assign h5 = hum_calib_b[31:16];
  assign h6 = hum_calib_b[39:32];

  logic [31:0] x1;
  logic [31:0] r1_m5, r1_m6, r1_m3;
  logic [15:0] r1_adc;
  logic [31:0] a_pre;
  logic [31:0] r2_a, r2_b, r2_c;
  logic [31:0] r3_a, r3_bc;
  logic [31:0] d4;
  logic [31:0] r4_a, r4_dm;
  logic [31:0] r5_a, r5_e;
  logic [31:0] r6_x2;
  logic [31:0] s7;
  logic [31:0] r7_x2, r7_sq;
  logic [31:0] r8_x2, r8_q;
  logic [31:0] y9, clamp9;

  assign x1    = tf - HumTfOffset;
  assign a_pre = {2'b0, r1_adc, 14'b0} - {h4[11:0], 20'b0} - r1_m5 + HumRound;
  assign d4    = asr32(r3_bc, 10) + HumDOffset;
  assign s7    = asr32(r6_x2, 15);
  assign y9    = r8_x2 - asr32(r8_q, 4);

  always_comb begin
    priority if (y9[31]) begin
      clamp9 = '0;
    end else if (y9 > HumMax) begin
      clamp9 = HumMax;
    end else begin
      clamp9 = y9;
    end
  end

  always_ff @(posedge clk) begin
    r1_m5  <= x1 * {{16{h5[15]}}, h5};
    r1_m6  <= x1 * {{24{h6[7]}}, h6};
    r1_m3  <= x1 * {24'b0, h3};
    r1_adc <= adc_humidity;
    r2_a   <= asr32(a_pre, 15);
    r2_b   <= asr32(r1_m6, 10);
    r2_c   <= asr32(r1_m3, 11) + HumCOffset;
    r3_a   <= r2_a;
    r3_bc  <= r2_b * r2_c;
    r4_a   <= r3_a;
    r4_dm  <= d4 * {{16{h2[15]}}, h2};
    r5_a   <= r4_a;
    r5_e   <= asr32(r4_dm + HumERound, 14);
    r6_x2  <= r5_a * r5_e;
    r7_x2  <= r6_x2;
    r7_sq  <= s7 * s7;
    r8_x2  <= r7_x2;
    r8_q   <= asr32(r7_sq, 7) * {24'b0, h1};
    humidity <= clamp9[28:12];
  end

endmodule

>>> rtl/core/thp_div.sv
// Fully pipelined restoring divider, one quotient bit per stage, with side payload.
module thp_div import thp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  div_req_t  req,
  output logic      out_valid,
  output div_resp_t resp
);

  typedef struct packed {
    logic [DvsBits-1:0] rem;
    logic [DivBits-1:0] work;
    logic [DvsBits-1:0] divisor;
    logic               neg;
    logic               zero;
    side_t              side;
  } stage_t;

  stage_t           st      [0:DivStages];
  stage_t           st_next [1:DivStages];
  logic [DivStages:0] vld;

  for (genvar k = 0; k < DivStages; k++) begin : g_step
    logic [DvsBits:0] trial;
    logic [DvsBits:0] diff;
    assign trial = {st[k].rem, st[k].work[DivBits-1]};
    assign diff  = trial - {1'b0, st[k].divisor};
    assign st_next[k+1] = '{
      rem:     (diff[DvsBits] ? trial[DvsBits-1:0] : diff[DvsBits-1:0]),
      work:    {st[k].work[DivBits-2:0], ~diff[DvsBits]},
      divisor: st[k].divisor,
      neg:     st[k].neg,
      zero:    st[k].zero,
      side:    st[k].side
    };
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DivStages-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= '{rem: '0, work: req.dividend, divisor: req.divisor,
               neg: req.neg, zero: req.zero, side: req.side};
    for (int k = 1; k <= DivStages; k++) begin
      st[k] <= st_next[k];
    end
  end

  assign out_valid = vld[DivStages];
  assign resp      = '{quo: st[DivStages].work, neg: st[DivStages].neg,
                       zero: st[DivStages].zero, side: st[DivStages].side};

endmodule

>>> rtl/core/thp_sensor_compensation.sv
// Top level of the temperature, pressure and humidity compensation pipeline.
// A result strobes done once its request has passed the front stages, the divider and the back stages.
// Throughput: one request per cycle while busy is low; the pressure divider is 64 pipelined stages.
// The receiver cannot stall, so busy is only high while rst is asserted.
// Synchronous reset clears the calibration registers and all valid bits.
module thp_sensor_compensation import thp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  in_item_t                request,
  input  logic                    wr_en,
  input  logic [CfgIndexBits-1:0] wr_index,
  input  logic [CfgDataBits-1:0]  wr_data,
  output logic                    done,
  output out_item_t               result
);

  logic [47:0] temp_calib, press_calib_a, press_calib_b, press_calib_c;
  logic [31:0] hum_calib_a;
  logic [39:0] hum_calib_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
      hum_calib_a   <= '0;
      hum_calib_b   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegTempCalib:   temp_calib    <= wr_data;
        RegPressCalibA: press_calib_a <= wr_data;
        RegPressCalibB: press_calib_b <= wr_data;
        RegPressCalibC: press_calib_c <= wr_data;
        RegHumCalibA:   hum_calib_a   <= wr_data[31:0];
        RegHumCalibB:   hum_calib_b   <= wr_data[39:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_calib[15:0];
  assign t2 = temp_calib[31:16];
  assign t3 = temp_calib[47:32];
  assign p1 = press_calib_a[15:0];
  assign p2 = press_calib_a[31:16];
  assign p3 = press_calib_a[47:32];
  assign p4 = press_calib_b[15:0];
  assign p5 = press_calib_b[31:16];
  assign p6 = press_calib_b[47:32];
  assign p7 = press_calib_c[15:0];
  assign p8 = press_calib_c[31:16];
  assign p9 = press_calib_c[47:32];

  logic accept;
  logic div_valid;
  logic [FrontStages:0] fv;
  logic [BackStages-1:0] qv;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      qv <= '0;
    end else begin
      fv <= {fv[FrontStages-1:0], accept};
      qv <= {qv[BackStages-2:0], div_valid};
    end
  end

  in_item_t    s0_item;
  logic [19:0] adc_p_d [1:8];
  logic [15:0] adc_h_d [1:3];
  logic [31:0] tf_d [4:12];
  logic [31:0] tc_d [4:12];

  logic [17:0]        ta;
  logic [16:0]        dt;
  logic signed [33:0] m1_full, sq_full;
  logic [31:0]        s1_m1, s1_sq;
  logic [31:0]        a12;
  logic signed [35:0] v2m_full;
  logic [31:0]        s2_v1, s2_v2m;
  logic [31:0]        s3_tf;

  assign ta       = {1'b0, s0_item.adc_temperature[19:3]} - {t1, 1'b0};
  assign dt       = {1'b0, s0_item.adc_temperature[19:4]} - {1'b0, t1};
  assign m1_full  = $signed(ta) * t2;
  assign sq_full  = $signed(dt) * $signed(dt);
  assign a12      = asr32(s1_sq, 12);
  assign v2m_full = $signed(a12[19:0]) * t3;

  logic signed [32:0] s4_pv1;
  logic signed [65:0] psq_full;
  logic signed [48:0] pm5_full, pm2_full;
  logic [63:0]        s5_psq;
  logic signed [48:0] s5_pm5, s5_pm2;
  logic signed [48:0] sq6a, sq3a;
  logic signed [48:0] s6_sq6a, s6_sq3a, s6_pm5, s6_pm2;
  logic [31:0]        s6_sq6b, s6_sq3b;
  logic [63:0]        s7_sq6, s7_sq3;
  logic signed [48:0] s7_pm5, s7_pm2;
  logic [63:0]        s8_v2, s8_v1b;
  logic [63:0]        s9_s1, s9_pre;
  logic [47:0]        s10_wl;
  logic [31:0]        s10_wh, s10_nh;
  logic [43:0]        s10_nl;
  logic [63:0]        s11_w, s11_num;
  logic [DvsBits-1:0] dv;
  logic [DivBits-1:0] s12_ma;
  logic [DvsBits-1:0] s12_mb;
  logic               s12_neg, s12_zero;
  logic [16:0]        hum_q10;

  assign psq_full = s4_pv1 * s4_pv1;
  assign pm5_full = s4_pv1 * p5;
  assign pm2_full = s4_pv1 * p2;
  assign sq6a     = $signed({1'b0, s5_psq[31:0]}) * p6;
  assign sq3a     = $signed({1'b0, s5_psq[31:0]}) * p3;
  assign dv       = s11_w[63:33];

  always_ff @(posedge clk) begin
    s0_item    <= request;
    adc_p_d[1] <= s0_item.adc_pressure;
    for (int k = 2; k <= 8; k++) begin
      adc_p_d[k] <= adc_p_d[k-1];
    end
    adc_h_d[1] <= s0_item.adc_humidity;
    for (int k = 2; k <= 3; k++) begin
      adc_h_d[k] <= adc_h_d[k-1];
    end

    s1_m1  <= m1_full[31:0];
    s1_sq  <= sq_full[31:0];
    s2_v1  <= asr32(s1_m1, 11);
    s2_v2m <= v2m_full[31:0];
    s3_tf  <= s2_v1 + asr32(s2_v2m, 14);

    tf_d[4] <= s3_tf;
    tc_d[4] <= asr32({s3_tf[29:0], 2'b0} + s3_tf + 32'd128, 8);
    for (int k = 5; k <= 12; k++) begin
      tf_d[k] <= tf_d[k-1];
      tc_d[k] <= tc_d[k-1];
    end

    s4_pv1  <= $signed({s3_tf[31], s3_tf}) - PressTfOffset;
    s5_psq  <= psq_full[63:0];
    s5_pm5  <= pm5_full;
    s5_pm2  <= pm2_full;
    s6_sq6a <= sq6a;
    s6_sq3a <= sq3a;
    s6_sq6b <= s5_psq[63:32] * {{16{p6[15]}}, p6};
    s6_sq3b <= s5_psq[63:32] * {{16{p3[15]}}, p3};
    s6_pm5  <= s5_pm5;
    s6_pm2  <= s5_pm2;
    s7_sq6  <= 64'(s6_sq6a) + {s6_sq6b, 32'b0};
    s7_sq3  <= 64'(s6_sq3a) + {s6_sq3b, 32'b0};
    s7_pm5  <= s6_pm5;
    s7_pm2  <= s6_pm2;
    s8_v2   <= s7_sq6 + (64'(s7_pm5) << 17) + (64'(p4) << 35);
    s8_v1b  <= asr64(s7_sq3, 8) + (64'(s7_pm2) << 12);
    s9_s1   <= PressBias + s8_v1b;
    s9_pre  <= ((PressAdcFull - {44'b0, adc_p_d[8]}) << 31) - s8_v2;
    s10_wl  <= s9_s1[31:0] * p1;
    s10_wh  <= s9_s1[63:32] * {16'b0, p1};
    s10_nl  <= s9_pre[31:0] * PressNumScale;
    s10_nh  <= s9_pre[63:32] * {20'b0, PressNumScale};
    s11_w   <= {16'b0, s10_wl} + {s10_wh, 32'b0};
    s11_num <= {20'b0, s10_nl} + {s10_nh, 32'b0};
    s12_zero <= (dv == '0);
    s12_mb   <= s11_w[63] ? (31'd0 - dv) : dv;
    s12_ma   <= s11_num[63] ? (64'd0 - s11_num) : s11_num;
    s12_neg  <= s11_num[63] ^ s11_w[63];
  end

  thp_hum u_hum (
    .clk          (clk),
    .tf           (s3_tf),
    .adc_humidity (adc_h_d[3]),
    .hum_calib_a  (hum_calib_a),
    .hum_calib_b  (hum_calib_b),
    .humidity     (hum_q10)
  );

  div_req_t  div_req;
  div_resp_t div_resp;

  assign div_req = '{dividend: s12_ma, divisor: s12_mb, neg: s12_neg, zero: s12_zero,
                     side: '{tf: tf_d[12], tc: tc_d[12], hum: hum_q10}};

  thp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv[FrontStages]),
    .req       (div_req),
    .out_valid (div_valid),
    .resp      (div_resp)
  );

  logic [63:0]        q0_p;
  logic               q0_zero;
  side_t              q0_side;
  logic [63:0]        qa;
  logic signed [48:0] m8a;
  logic [63:0]        q1_p, q1_pp0;
  logic [31:0]        q1_pp1, q1_m8b;
  logic signed [48:0] q1_m8a;
  logic               q1_zero;
  side_t              q1_side;
  logic [63:0]        q2_p, q2_aa, q2_m8;
  logic               q2_zero;
  side_t              q2_side;
  logic signed [48:0] t9a;
  logic [31:0]        t9b;
  logic [63:0]        q3_p, q3_t9, q3_v2;
  logic               q3_zero;
  side_t              q3_side;
  logic [63:0]        pr;

  assign qa  = asr64(q0_p, 13);
  assign m8a = $signed({1'b0, q0_p[31:0]}) * p8;
  assign t9a = $signed({1'b0, q2_aa[31:0]}) * p9;
  assign t9b = q2_aa[63:32] * {{16{p9[15]}}, p9};
  assign pr  = asr64(q3_p + asr64(q3_t9, 25) + q3_v2, 8) + (64'(p7) << 4);

  always_ff @(posedge clk) begin
    q0_p    <= div_resp.neg ? (64'd0 - div_resp.quo) : div_resp.quo;
    q0_zero <= div_resp.zero;
    q0_side <= div_resp.side;

    q1_p    <= q0_p;
    q1_pp0  <= qa[31:0] * qa[31:0];
    q1_pp1  <= qa[31:0] * qa[63:32];
    q1_m8a  <= m8a;
    q1_m8b  <= q0_p[63:32] * {{16{p8[15]}}, p8};
    q1_zero <= q0_zero;
    q1_side <= q0_side;

    q2_p    <= q1_p;
    q2_aa   <= q1_pp0 + {q1_pp1[30:0], 33'b0};
    q2_m8   <= 64'(q1_m8a) + {q1_m8b, 32'b0};
    q2_zero <= q1_zero;
    q2_side <= q1_side;

    q3_p    <= q2_p;
    q3_t9   <= 64'(t9a) + {t9b, 32'b0};
    q3_v2   <= asr64(q2_m8, 19);
    q3_zero <= q2_zero;
    q3_side <= q2_side;

    result.fine_temperature  <= q3_side.tf;
    result.temperature_centi <= q3_side.tc;
    result.pressure_q8       <= q3_zero ? 32'd0 : pr[31:0];
    result.humidity_q10      <= q3_side.hum;
  end

  assign done = qv[BackStages-1];

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) accept |-> ##(Latency + 1) done)
    else $error("Accepted request produced no result at the expected cycle.");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, Latency + 1))
    else $error("Result strobe without a matching request.");
  assert property (@(posedge clk) disable iff (rst)
      div_valid |-> $past(fv[FrontStages], DivStages + 1))
    else $error("Divider output out of step with the front pipeline.");
  assert property (@(posedge clk) disable iff (rst) done |-> (result.humidity_q10 <= HumQ10Max))
    else $error("Humidity result exceeds the clamp limit.");
`endif

endmodule

>>> verif/thp_sensor_compensation_tb.sv
// Testbench of the sensor compensation pipeline: directed table, random phases, own predictor.
module thp_sensor_compensation_tb import thp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {
    CAL_RESET, CAL_TYPICAL, CAL_NODIV, CAL_ONES, CAL_MAXPOS, CAL_MINNEG, CAL_RANDOM
  } calib_set_t;

  typedef struct {
    calib_set_t set;
    in_item_t   req;
    bit         typed;
    out_item_t  exp;
  } stim_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_item_t request;
  logic wr_en;
  logic [CfgIndexBits-1:0] wr_index;
  logic [CfgDataBits-1:0] wr_data;
  logic done;
  out_item_t result;

  logic [47:0] calib [0:5];
  out_item_t expected_results [$];
  stim_row_t stim_rows [$];
  int errors = 0;

  thp_sensor_compensation u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    return x[31] ? ~((~x) >> n) : (x >> n);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int n);
    return x[63] ? ~((~x) >> n) : (x >> n);
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] f);
    return {{48{f[15]}}, f};
  endfunction

  function automatic out_item_t compensate(in_item_t s);
    out_item_t r;
    logic [47:0] tc, pa, pb, pc;
    logic [31:0] at, t1, t2, t3, v1, v2, dt, tf;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, q1, q2, pp, num, ma, mb, qq;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, ha, hb, hc, hd, he;
    tc = calib[RegTempCalib];
    pa = calib[RegPressCalibA];
    pb = calib[RegPressCalibB];
    pc = calib[RegPressCalibC];
    at = {12'b0, s.adc_temperature};
    t1 = {16'b0, tc[15:0]};
    t2 = 32'(sx16(tc[31:16]));
    t3 = 32'(sx16(tc[47:32]));
    v1 = sra32(((at >> 3) - (t1 << 1)) * t2, 11);
    dt = (at >> 4) - t1;
    v2 = sra32(sra32(dt * dt, 12) * t3, 14);
    tf = v1 + v2;
    r.fine_temperature = tf;
    r.temperature_centi = sra32(tf * 32'd5 + 32'd128, 8);

    p1 = {48'b0, pa[15:0]};
    p2 = sx16(pa[31:16]);
    p3 = sx16(pa[47:32]);
    p4 = sx16(pb[15:0]);
    p5 = sx16(pb[31:16]);
    p6 = sx16(pb[47:32]);
    p7 = sx16(pc[15:0]);
    p8 = sx16(pc[31:16]);
    p9 = sx16(pc[47:32]);
    q1 = {{32{tf[31]}}, tf} - 64'd128000;
    q2 = q1 * q1 * p6;
    q2 = q2 + ((q1 * p5) << 17);
    q2 = q2 + (p4 << 35);
    q1 = sra64(q1 * q1 * p3, 8) + ((q1 * p2) << 12);
    q1 = sra64((64'h0000_8000_0000_0000 + q1) * p1, 33);
    if (q1 == 64'd0) begin
      r.pressure_q8 = 32'd0;
    end else begin
      pp = 64'd1048576 - {44'b0, s.adc_pressure};
      num = ((pp << 31) - q2) * 64'd3125;
      ma = num[63] ? (64'd0 - num) : num;
      mb = q1[63] ? (64'd0 - q1) : q1;
      qq = ma / mb;
      pp = (num[63] != q1[63]) ? (64'd0 - qq) : qq;
      q1 = sra64(p9 * sra64(pp, 13) * sra64(pp, 13), 25);
      q2 = sra64(p8 * pp, 19);
      pp = sra64(pp + q1 + q2, 8) + (p7 << 4);
      r.pressure_q8 = pp[31:0];
    end

    h1 = {24'b0, calib[RegHumCalibA][7:0]};
    h2 = 32'(sx16(calib[RegHumCalibA][23:8]));
    h3 = {24'b0, calib[RegHumCalibA][31:24]};
    h4 = 32'(sx16(calib[RegHumCalibB][15:0]));
    h5 = 32'(sx16(calib[RegHumCalibB][31:16]));
    h6 = {{24{calib[RegHumCalibB][39]}}, calib[RegHumCalibB][39:32]};
    x = tf - 32'd76800;
    ha = sra32(({16'b0, s.adc_humidity} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    hb = sra32(x * h6, 10);
    hc = sra32(x * h3, 11) + 32'd32768;
    hd = sra32(hb * hc, 10) + 32'd2097152;
    he = sra32(hd * h2 + 32'd8192, 14);
    x = ha * he;
    x = x - sra32(sra32(sra32(x, 15) * sra32(x, 15), 7) * h1, 4);
    if (x[31]) x = 32'd0;
    if (x > 32'd419430400) x = 32'd419430400;
    r.humidity_q10 = x[28:12];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 64'(result.pressure_q8), 64'd0);
      end else begin
        e = expected_results.pop_front();
        if (result.fine_temperature !== e.fine_temperature)
          report("fine_temperature", 64'(result.fine_temperature),
                 64'(e.fine_temperature));
        if (result.temperature_centi !== e.temperature_centi)
          report("temperature_centi", 64'(result.temperature_centi),
                 64'(e.temperature_centi));
        if (result.pressure_q8 !== e.pressure_q8)
          report("pressure_q8", 64'(result.pressure_q8), 64'(e.pressure_q8));
        if (result.humidity_q10 !== e.humidity_q10)
          report("humidity_q10", 64'(result.humidity_q10), 64'(e.humidity_q10));
      end
    end
  end

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_calibration(calib_set_t set);
    logic [47:0] v [0:5];
    logic [47:0] d;
    case (set)
      CAL_TYPICAL, CAL_NODIV: begin
        v[0] = 48'hFC18_6743_6B70;
        v[1] = 48'h0BD0_D643_8E7D;
        v[2] = 48'hFFF9_008C_0B27;
        v[3] = 48'h1770_C6F8_3C8C;
        v[4] = 48'h0000_016A_4B;
        v[5] = 48'h1E_0032_0139;
        if (set == CAL_NODIV) v[1][15:0] = 16'h0000;
      end
      CAL_ONES:   foreach (v[i]) v[i] = 48'hFFFF_FFFF_FFFF;
      CAL_MAXPOS: foreach (v[i]) v[i] = 48'h7FFF_7FFF_7FFF;
      CAL_MINNEG: foreach (v[i]) v[i] = 48'h8000_8000_8000;
      default:    foreach (v[i]) v[i] = 48'({$urandom(), $urandom()});
    endcase
    for (int i = 0; i <= 6; i++) begin
      d = (i <= 5) ? v[i] : 48'({$urandom(), $urandom()});
      wr_en <= 1'b1;
      wr_index <= CfgIndexBits'(i);
      wr_data <= d;
      @(posedge clk);
      case (CfgIndexBits'(i))
        RegTempCalib, RegPressCalibA, RegPressCalibB, RegPressCalibC: calib[i] = d;
        RegHumCalibA: calib[i] = {16'b0, d[31:0]};
        RegHumCalibB: calib[i] = {8'b0, d[39:0]};
        default: ;
      endcase
    end
    wr_en <= 1'b0;
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t exp);
    start <= 1'b1;
    request <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(typed ? exp : compensate(it));
  endtask

  task automatic add_row(calib_set_t set, logic [19:0] t, logic [19:0] p, logic [15:0] h,
                         bit typed);
    stim_row_t r;
    r.set = set;
    r.req = '{adc_temperature: t, adc_pressure: p, adc_humidity: h};
    r.typed = typed;
    r.exp = '0;
    stim_rows.push_back(r);
  endtask

  initial begin
    calib_set_t cur;
    in_item_t it;
    int idle_pct;
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    foreach (calib[i]) calib[i] = '0;

    // With every calibration word cleared, all outputs are zero.
    add_row(CAL_RESET, 20'h00000, 20'h00000, 16'h0000, 1);
    add_row(CAL_RESET, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1);
    add_row(CAL_RESET, 20'h80000, 20'h80000, 16'h8000, 1);
    add_row(CAL_RESET, 20'h7FFFF, 20'h7FFFF, 16'h7FFF, 1);
    add_row(CAL_TYPICAL, 20'd519888, 20'd415148, 16'd30000, 0);
    add_row(CAL_TYPICAL, 20'd519888, 20'd415148, 16'h0000, 0);
    add_row(CAL_TYPICAL, 20'd519888, 20'd415148, 16'hFFFF, 0);
    add_row(CAL_TYPICAL, 20'h00000, 20'h00000, 16'd20000, 0);
    add_row(CAL_TYPICAL, 20'hFFFFF, 20'hFFFFF, 16'd40000, 0);
    add_row(CAL_TYPICAL, 20'd400000, 20'hFFFFF, 16'd25000, 0);
    add_row(CAL_NODIV, 20'd519888, 20'd415148, 16'd30000, 0);
    add_row(CAL_NODIV, 20'hFFFFF, 20'h00000, 16'hFFFF, 0);
    add_row(CAL_ONES, 20'h00000, 20'h00000, 16'h0000, 0);
    add_row(CAL_ONES, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
    add_row(CAL_MAXPOS, 20'h00000, 20'hFFFFF, 16'h0000, 0);
    add_row(CAL_MAXPOS, 20'hFFFFF, 20'h00000, 16'hFFFF, 0);
    add_row(CAL_MINNEG, 20'h00000, 20'h00000, 16'hFFFF, 0);
    add_row(CAL_MINNEG, 20'hFFFFF, 20'hFFFFF, 16'h0000, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur = CAL_RESET;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].set != cur) begin
        start <= 1'b0;
        wait_drained();
        cur = stim_rows[i].set;
        load_calibration(cur);
      end
      send_item(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].exp);
    end
    start <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: cur = CAL_TYPICAL;
        1: cur = CAL_RANDOM;
        2: cur = CAL_NODIV;
        3: cur = CAL_ONES;
        4: cur = CAL_TYPICAL;
        5: cur = CAL_MAXPOS;
        6: cur = CAL_MINNEG;
        default: cur = CAL_RANDOM;
      endcase
      load_calibration(cur);
      idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 56 : 7);
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(1)) begin
          it.adc_temperature = 20'($urandom_range(600000, 400000));
          it.adc_pressure = 20'($urandom_range(600000, 200000));
          it.adc_humidity = 16'($urandom());
        end else begin
          it = in_item_t'(56'({$urandom(), $urandom()}));
        end
        if ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk);
          while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        send_item(it, 0, '0);
      end
      start <= 1'b0;
    end

    while (expected_results.size() != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
